@@ rtl/core/ceov_pkg.sv @@
`default_nettype none

package ceov_pkg;

    // Number of cells in the chain, one held value per cell.
    localparam int DEPTH = 64;
    // Count of held values, wide enough to hold DEPTH itself.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int VAL_W = 32;
    // Result transfer: value, found flag and full flag, padded to whole bytes.
    localparam int OUT_W = ((VAL_W + 2 + 7) / 8) * 8;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_FINISH
    } state_t;

    // Search token that walks down the chain, one cell per cycle.
    typedef struct packed {
        logic                    vld;
        logic signed [VAL_W-1:0] sample;
        logic                    hit;
        logic signed [VAL_W-1:0] best;
        logic                    dup;
    } tok_t;

endpackage

`default_nettype wire

@@ rtl/core/ceov_cell.sv @@
`default_nettype none

module ceov_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire ceov_pkg::tok_t tok_in,
    output ceov_pkg::tok_t      tok_out,
    input  wire logic          wr_en,
    input  wire logic signed [ceov_pkg::VAL_W-1:0] wr_value,
    input  wire logic          clr
);

    logic signed [ceov_pkg::VAL_W-1:0] held_reg;
    logic                              valid_reg;
    logic                              valid_next;
    ceov_pkg::tok_t                    tok_reg;
    ceov_pkg::tok_t                    tok_next;

    // Fold this cell's value into the passing token.
    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.vld && valid_reg)
        begin
            if (held_reg >= tok_in.sample && (!tok_in.hit || held_reg < tok_in.best))
            begin
                tok_next.hit  = 1'b1;
                tok_next.best = held_reg;
            end
            if (held_reg == tok_in.sample)
            begin
                tok_next.dup = 1'b1;
            end
        end
    end

    // Clearing takes precedence over a write in the same cycle.
    always_comb
    begin
        valid_next = valid_reg;
        if (clr)
        begin
            valid_next = 1'b0;
        end
        else if (wr_en)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            held_reg <= wr_value;
        end
    end

    assign tok_out = tok_reg;

endmodule

`default_nettype wire

@@ rtl/core/ceiling_of_earlier_values.sv @@
// Ceiling of earlier values over a stream of signed 32-bit samples.
// Input channel s_axis: tdata[31:0] is the sample, tlast marks the last sample
// of a sequence; after that sample's result the held set is emptied.
// Output channel m_axis: one transfer per input transfer, carrying the smallest
// earlier sample that is greater than or equal to the current one, a found
// flag, and a full flag raised when a new sample could not be kept.
// Each sample walks a chain of DEPTH cells, one cell per cycle, and every cell
// compares its held value with it. A sample is taken only while no other is in
// the chain, so the block takes no new sample until the previous sample's result
// has been placed in the output register. A sample passes the DEPTH cell
// registers and the finish register, and its result then enters the output register.
// The result sits in an output register; the next sample is taken while it
// waits. If the receiver stalls, the following sample waits at the end of the
// chain until the output register is free, and input stays blocked meanwhile.
// Reset empties the held set and the output register; no sweep is needed.
`default_nettype none

module ceiling_of_earlier_values (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       s_axis_tvalid,
    output logic                            s_axis_tready,
    // Fields from bit 0 up: sample_value[31:0].
    input  wire logic [ceov_pkg::VAL_W-1:0] s_axis_tdata,
    // ends_sequence.
    input  wire logic                       s_axis_tlast,
    output logic                            m_axis_tvalid,
    input  wire logic                       m_axis_tready,
    // Fields from bit 0 up: ceiling_value[31:0], ceiling_found, store_full,
    // then zero padding.
    output logic [ceov_pkg::OUT_W-1:0]      m_axis_tdata
);

    ceov_pkg::state_t state_reg;
    ceov_pkg::state_t state_next;

    ceov_pkg::tok_t tok [0:ceov_pkg::DEPTH];
    ceov_pkg::tok_t fin_reg;
    ceov_pkg::tok_t fin_next;

    logic                        ends_reg;
    logic                        ends_next;
    logic [ceov_pkg::CNT_W-1:0]  cnt_reg;
    logic [ceov_pkg::CNT_W-1:0]  cnt_next;
    logic                        out_vld_reg;
    logic                        out_vld_next;
    logic [ceov_pkg::OUT_W-1:0]  out_data_reg;
    logic [ceov_pkg::OUT_W-1:0]  out_data_next;

    logic in_xfer;
    logic slot_free;
    logic retire;
    logic is_full;
    logic do_insert;
    logic do_clear;

    assign slot_free = !out_vld_reg || m_axis_tready;
    assign in_xfer   = s_axis_tvalid && s_axis_tready;
    assign is_full   = (cnt_reg == ceov_pkg::CNT_W'(ceov_pkg::DEPTH));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ceov_pkg::ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    state_next = ceov_pkg::ST_SEARCH;
                end
            end
            ceov_pkg::ST_SEARCH:
            begin
                if (tok[ceov_pkg::DEPTH].vld)
                begin
                    state_next = ceov_pkg::ST_FINISH;
                end
            end
            ceov_pkg::ST_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = ceov_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ceov_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb
    begin
        s_axis_tready = 1'b0;
        retire        = 1'b0;
        case (state_reg)
            ceov_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            ceov_pkg::ST_SEARCH:
            begin
                retire = 1'b0;
            end
            ceov_pkg::ST_FINISH:
            begin
                retire = slot_free;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // The launched token starts with no match: fields are vld, sample, hit,
    // best and dup from the top bit down.
    assign tok[0] = {in_xfer, s_axis_tdata, 1'b0, {ceov_pkg::VAL_W{1'b0}}, 1'b0};

    // A new sample is kept in the next free cell; held values always fill
    // the chain from cell 0 up, so that cell is the one at the count.
    assign do_insert = retire && !fin_reg.dup && !is_full;
    assign do_clear  = retire && ends_reg;

    genvar j;
    generate
        for (j = 0; j < ceov_pkg::DEPTH; j++)
        begin : g_cell
            ceov_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .tok_in   (tok[j]),
                .tok_out  (tok[j+1]),
                .wr_en    (do_insert && (cnt_reg == ceov_pkg::CNT_W'(j))),
                .wr_value (fin_reg.sample),
                .clr      (do_clear)
            );
        end
    endgenerate

    always_comb
    begin
        fin_next      = fin_reg;
        ends_next     = ends_reg;
        cnt_next      = cnt_reg;
        out_vld_next  = out_vld_reg;
        out_data_next = out_data_reg;

        if (in_xfer)
        begin
            ends_next = s_axis_tlast;
        end
        if (state_reg == ceov_pkg::ST_SEARCH && tok[ceov_pkg::DEPTH].vld)
        begin
            fin_next = tok[ceov_pkg::DEPTH];
        end

        if (out_vld_reg && m_axis_tready)
        begin
            out_vld_next = 1'b0;
        end

        if (retire)
        begin
            out_vld_next = 1'b1;
            out_data_next = '0;
            out_data_next[ceov_pkg::VAL_W-1:0] = fin_reg.hit ? fin_reg.best : '0;
            out_data_next[ceov_pkg::VAL_W]     = fin_reg.hit;
            out_data_next[ceov_pkg::VAL_W+1]   = !fin_reg.dup && is_full;
            if (ends_reg)
            begin
                cnt_next = '0;
            end
            else if (do_insert)
            begin
                cnt_next = cnt_reg + ceov_pkg::CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ceov_pkg::ST_IDLE;
            cnt_reg     <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        fin_reg      <= fin_next;
        ends_reg     <= ends_next;
        out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ test/ceiling_result_checker.sv @@
`timescale 1ns / 100ps

// Watches both stream channels of the ceiling block. It keeps its own copy of the
// held set, predicts one result for every accepted sample, and compares each
// result transfer with the oldest prediction still waiting.
module ceiling_result_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_axis_tvalid,
    input  wire logic                          s_axis_tready,
    input  wire logic [ceov_pkg::VAL_W-1:0]    s_axis_tdata,
    input  wire logic                          s_axis_tlast,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [ceov_pkg::OUT_W-1:0]    m_axis_tdata,
    output int                                 mismatch_count,
    output int                                 pending
);

    localparam int PAD_W      = ceov_pkg::OUT_W - ceov_pkg::VAL_W - 2;
    localparam int REPORT_MAX = 10;

    typedef logic signed [ceov_pkg::VAL_W-1:0] sample_t;

    // Result transfer layout, lowest bits last in the declaration.
    typedef struct packed {
        logic [PAD_W-1:0] pad;
        logic             full;
        logic             found;
        sample_t          ceiling;
    } ceiling_result_t;

    sample_t         held_set[$];
    ceiling_result_t expected_results[$];
    int              result_index;

    initial begin
        mismatch_count = 0;
        pending        = 0;
        result_index   = 0;
    end

    // Ceiling of one sample against the held set, then the set update.
    function automatic ceiling_result_t find_ceiling(input sample_t sample, input logic ends);
        ceiling_result_t res;
        sample_t         best;
        logic            present;
        res     = '0;
        best    = '0;
        present = 1'b0;
        foreach (held_set[i]) begin
            if (held_set[i] == sample)
                present = 1'b1;
            if (held_set[i] >= sample && (!res.found || held_set[i] < best)) begin
                res.found = 1'b1;
                best      = held_set[i];
            end
        end
        res.ceiling = best;
        if (!present) begin
            if (held_set.size() >= ceov_pkg::DEPTH)
                res.full = 1'b1;
            else
                held_set.push_back(sample);
        end
        // The end of a sequence empties the set only after the result is formed.
        if (ends)
            held_set.delete();
        return res;
    endfunction

    // All stimulus changes at rising edges, so the falling edge sees settled
    // values that the next rising edge will act on.
    always @(negedge clk) begin
        ceiling_result_t got;
        ceiling_result_t want;
        if (rst_n) begin
            // Results first: a result can never belong to a sample taken in the same cycle.
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("[%0t] result %0d arrived with no sample waiting: tdata=%h",
                                 $time, result_index, m_axis_tdata);
                end
                else begin
                    want = expected_results.pop_front();
                    if (got.ceiling !== want.ceiling || got.found !== want.found ||
                        got.full !== want.full || got.pad !== want.pad) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX) begin
                            $display("[%0t] result %0d mismatch: expected ceiling=%0d found=%b full=%b pad=%h",
                                     $time, result_index, $signed(want.ceiling), want.found,
                                     want.full, want.pad);
                            $display("    got ceiling=%0d found=%b full=%b pad=%h",
                                     $signed(got.ceiling), got.found, got.full, got.pad);
                        end
                    end
                end
                result_index++;
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(find_ceiling(s_axis_tdata, s_axis_tlast));
            pending = expected_results.size();
        end
    end

endmodule

@@ test/ceiling_of_earlier_values_tb.sv @@
`timescale 1ns / 100ps

// Stimulus and verdict for the ceiling block. The checker beside the block does
// all prediction and comparison; this module only drives the two channels,
// paces them, and decides the outcome once everything has drained.
module ceiling_of_earlier_values_tb;

    // Target number of samples, directed ones included.
    localparam int ITEM_TARGET = 750;
    // One sample walks all cells before its result appears.
    localparam int LATENCY     = ceov_pkg::DEPTH + 1;
    // Long receiver hold-off, far beyond the chain latency so the input backs up.
    localparam int HOLD_CYCLES = 500;
    localparam int HOLD_AFTER  = 300;
    // Cycles after the last result during which nothing more may come out.
    localparam int DRAIN       = 2 * LATENCY + 10;
    // This limit is well above the slowest legal run.
    localparam int LIMIT       = 1000000;
    localparam int HISTORY_MAX = 32;

    // How the values of one sequence are chosen.
    typedef enum int {
        MIX_NARROW,     // small values around zero, many repeats and ties
        MIX_WIDE,       // full 32-bit range, nearly all distinct
        MIX_BLEND       // extremes, small values, recent values and random ones
    } value_mix_t;

    // Receiver pacing modes, each held for a random number of cycles.
    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_RARELY,
        RX_TOGGLE
    } rx_mode_t;

    logic                          clk;
    logic                          rst_n;
    logic                          s_axis_tvalid;
    logic                          s_axis_tready;
    // Fields from bit 0 up: sample_value[31:0].
    logic [ceov_pkg::VAL_W-1:0]    s_axis_tdata;
    // ends_sequence.
    logic                          s_axis_tlast;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready;
    // Fields from bit 0 up: ceiling_value[31:0], ceiling_found, store_full, padding.
    logic [ceov_pkg::OUT_W-1:0]    m_axis_tdata;

    int                            mismatch_count;
    int                            pending;
    int                            sent_count;
    int                            burst_left;
    logic [ceov_pkg::VAL_W-1:0]    recent_values[$];

    ceiling_of_earlier_values DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    ceiling_result_checker result_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .s_axis_tlast   (s_axis_tlast),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Draws one sample value. Recent values are reused on purpose so that equal
    // values meet the held set, including large ones inside a full store.
    function automatic logic [ceov_pkg::VAL_W-1:0] pick_value(input value_mix_t mix);
        int sel;
        sel = $urandom_range(0, 9);
        if (recent_values.size() != 0 &&
            ((mix == MIX_NARROW && sel < 2) || (mix == MIX_WIDE && sel == 0) ||
             (mix == MIX_BLEND && sel >= 4 && sel < 6)))
            return recent_values[$urandom_range(0, recent_values.size() - 1)];
        if (mix == MIX_NARROW || (mix == MIX_BLEND && sel >= 1 && sel < 4))
            return $urandom_range(0, 31) - 16;
        if (mix == MIX_BLEND && sel == 0) begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom;
    endfunction

    // Offers one sample and returns at the rising edge where it is taken. The
    // sender works in bursts; at the end of a burst valid drops for a random gap.
    // Valid stays high between samples of a burst, so it is never lowered and
    // raised within one time step.
    task automatic send_sample(input logic [ceov_pkg::VAL_W-1:0] value, input logic last);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tlast  <= last;
        // Ready is settled at the falling edge; the transfer happens at the next
        // rising edge since nothing the block sees changes in between.
        @(negedge clk);
        while (!s_axis_tready)
            @(negedge clk);
        @(posedge clk);
        sent_count++;
        if (recent_values.size() == HISTORY_MAX)
            void'(recent_values.pop_front());
        recent_values.push_back(value);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            // Gaps range from none to longer than the chain, so they land on every
            // phase of a sample's walk.
            case ($urandom_range(0, 5))
                0, 1:    gap = 0;
                2, 3:    gap = $urandom_range(1, 8);
                4:       gap = $urandom_range(9, 40);
                default: gap = $urandom_range(41, 120);
            endcase
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic send_sequence(input int len, input value_mix_t mix);
        for (int k = 0; k < len; k++)
            send_sample(pick_value(mix), k == len - 1);
    endtask

    // Reset, directed samples, random sequences, drain and verdict.
    initial begin : stimulus
        int         len;
        value_mix_t mix;
        sent_count    = 0;
        burst_left    = $urandom_range(1, 16);
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: empty store, equal values, both extremes of the range,
        // zero and minus one, a clear in mid-stream and alternating bit patterns.
        send_sample(32'd5, 1'b0);           // nothing held yet
        send_sample(32'd5, 1'b0);           // equal value is its own ceiling
        send_sample(32'h7FFF_FFFF, 1'b0);   // largest value, nothing above it
        send_sample(32'h8000_0000, 1'b0);   // smallest value, ceiling is 5
        send_sample(32'd3, 1'b0);
        send_sample(32'd7, 1'b0);           // ceiling is the largest value
        send_sample(32'h7FFF_FFFF, 1'b0);
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'd0, 1'b0);
        send_sample(32'hFFFF_FFFF, 1'b0);   // minus one finds zero
        send_sample(32'd6, 1'b1);           // ends the sequence after its result
        send_sample(32'd6, 1'b0);           // store was emptied, nothing found
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h5555_5555, 1'b0);
        send_sample(32'hAAAA_AAAA, 1'b1);
        send_sample(32'hFFFF_FFFB, 1'b1);   // a sequence of one sample

        // Random sequences. The first is long enough to overflow the store, and
        // long ones recur so that full-store behavior and its clearing repeat.
        while (sent_count < ITEM_TARGET) begin
            case ($urandom_range(0, 19))
                0, 1, 2: begin
                    len = $urandom_range(ceov_pkg::DEPTH + 2, ceov_pkg::DEPTH + 26);
                    mix = MIX_WIDE;
                end
                3, 4, 5, 6: begin
                    len = $urandom_range(13, ceov_pkg::DEPTH - 1);
                    mix = MIX_BLEND;
                end
                default: begin
                    len = $urandom_range(1, 12);
                    mix = ($urandom_range(0, 1) != 0) ? MIX_NARROW : MIX_BLEND;
                end
            endcase
            if (sent_count < 20) begin
                len = $urandom_range(ceov_pkg::DEPTH + 2, ceov_pkg::DEPTH + 26);
                mix = MIX_WIDE;
            end
            send_sequence(len, mix);
        end
        s_axis_tvalid <= 1'b0;

        // Wait for every predicted result, then watch a while for stray ones.
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatch_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Receiver pacing. Each cycle gets exactly one ready assignment. Once, after
    // a few hundred samples, ready is held low for a long stretch while the sender
    // keeps offering, so the chain and the output register back up into the input.
    initial begin : receiver
        rx_mode_t mode;
        int       seg_left;
        int       hold_left;
        bit       hold_done;
        m_axis_tready <= 1'b0;
        mode      = RX_ALWAYS;
        seg_left  = 0;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (!hold_done && sent_count >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                m_axis_tready <= 1'b0;
            end
            else begin
                if (seg_left == 0) begin
                    mode     = rx_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (mode)
                    RX_ALWAYS: m_axis_tready <= 1'b1;
                    RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
                    RX_RARELY: m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready <= seg_left[0];
                endcase
            end
        end
    end

    // Ends a run that hangs.
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

endmodule
